### src/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared commands and the layout of one page entry of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam int   ORD_W     = 4;

    // One page entry: free head mark, allocated head mark, block order.
    typedef struct packed {
        logic             free_h;
        logic             alloc_h;
        logic [ORD_W-1:0] order;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

### src/bba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/buddy_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a region of 2^REGION_BITS bytes in pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one item: i_cmd (0 alloc, 1 free),
//   i_request_bytes for alloc and i_block_offset for free. Output channel
//   (o_valid/i_ready) returns exactly one item per input: o_ok, o_result_offset
//   and o_result_order (offset and order are zero for a free or a failure).
//   One item is worked on at a time. All page state lives in one RAM of
//   NPAGES entries with a registered read; each step reads an entry, waits for
//   its data or writes an entry back, so the RAM port sets the pace.
//   Allocation scans block heads in ascending address order and then splits
//   the chosen block down level by level; free checks at most TOP buddies.
//   After reset a clearing pass writes every entry (page 0 holds a free
//   block of the top order); o_ready stays low meanwhile.
//   A finished result waits in an output register; while the receiver
//   stalls the block holds it and accepts no new item.
//   Scan order: the lowest-address free block of the smallest fitting order
//   wins, so the scan remembers the best candidate over all block heads.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int PAGE_BITS   = 12,
    parameter int REGION_BITS = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output      logic                   o_ready,
    input  wire logic                   i_cmd,
    input  wire logic [20:0]            i_request_bytes,
    input  wire logic [REGION_BITS-1:0] i_block_offset,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      logic                   o_ok,
    output      logic [REGION_BITS-1:0] o_result_offset,
    output      logic [ORD_W-1:0]       o_result_order
);
    localparam int TOP    = REGION_BITS - PAGE_BITS;
    localparam int NPAGES = 1 << TOP;
    localparam int PW     = TOP;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;  // scan: data arriving
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_SPL   = 4'd4;  // write split halves
    localparam logic [3:0] S_AWR   = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_BRD   = 4'd8;
    localparam logic [3:0] S_BCHK  = 4'd9;
    localparam logic [3:0] S_FWR   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]        r_st, n_st;
    logic [PW:0]       r_pg, n_pg;      // scan page / clear counter
    logic [PW-1:0]     r_best, n_best;
    logic [ORD_W-1:0]  r_bord, n_bord;
    logic              r_found, n_found;
    logic [ORD_W-1:0]  r_want, n_want;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [PW-1:0]     r_page, n_page;
    logic              r_ok, n_ok;
    logic [REGION_BITS-1:0] r_off, n_off;
    logic [ORD_W-1:0]  r_ord, n_ord;

    logic              we;
    logic [PW-1:0]     waddr, raddr;
    t_entry            wdata, rdata;

    bba_ram #(.WIDTH(ENTRY_W), .DEPTH(NPAGES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // Smallest order holding the request; TOP+1 flags too large.
    logic [ORD_W-1:0] want_c;
    always_comb begin
        want_c = ORD_W'(TOP + 1);
        for (int k = TOP; k >= 0; k--) begin
            if ({43'd0, i_request_bytes} <= (64'd1 << (PAGE_BITS + k))) begin
                want_c = ORD_W'(k);
            end
        end
    end

    logic [PW-1:0] buddy;
    assign buddy = r_page ^ PW'(({{(PW-1){1'b0}}, 1'b1}) << r_k);

    assign o_ready         = (r_st == S_IDLE);
    assign o_valid         = (r_st == S_OUT);
    assign o_ok            = r_ok;
    assign o_result_offset = r_off;
    assign o_result_order  = r_ord;

    always_comb begin
        n_st = r_st; n_pg = r_pg; n_best = r_best; n_bord = r_bord;
        n_found = r_found; n_want = r_want; n_k = r_k; n_page = r_page;
        n_ok = r_ok; n_off = r_off; n_ord = r_ord;
        we = 1'b0; waddr = r_page; wdata = '0; raddr = r_pg[PW-1:0];
        case (r_st)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_pg[PW-1:0];
                wdata = (r_pg == '0) ? t_entry'{1'b1, 1'b0, ORD_W'(TOP)} : t_entry'('0);
                n_pg  = r_pg + 1'b1;
                if (r_pg == (PW+1)'(NPAGES - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                n_ok = 1'b0; n_off = '0; n_ord = '0;
                if (i_valid) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_want = want_c; n_pg = '0; n_found = 1'b0;
                        raddr = '0;
                        n_st = (want_c > ORD_W'(TOP)) ? S_OUT : S_SRD;
                    end else begin
                        n_page = i_block_offset[REGION_BITS-1:PAGE_BITS];
                        raddr  = i_block_offset[REGION_BITS-1:PAGE_BITS];
                        n_st = (i_block_offset[PAGE_BITS-1:0] != '0) ? S_OUT : S_FRD;
                    end
                end
            end
            S_SRD: n_st = S_SCHK;
            S_SCHK: begin
                // Every page here is a block head; step by its order.
                if (rdata.free_h && rdata.order >= r_want &&
                    (!r_found || rdata.order < r_bord)) begin
                    n_found = 1'b1; n_best = r_pg[PW-1:0]; n_bord = rdata.order;
                end
                n_pg  = r_pg + ((PW+1)'(1) << rdata.order);
                raddr = n_pg[PW-1:0];
                if (n_pg[PW] || n_pg[PW-1:0] == '0) begin
                    n_page = n_found ? n_best : r_best;
                    n_k    = n_bord;
                    n_st   = n_found ? S_SPL : S_OUT;
                end else begin
                    n_st = S_SRD;
                end
            end
            S_SPL: begin
                if (r_k == r_want) begin
                    n_st = S_AWR;
                end else begin
                    we    = 1'b1;
                    waddr = r_page + PW'(({{(PW-1){1'b0}}, 1'b1}) << (r_k - 1'b1));
                    wdata = '{1'b1, 1'b0, r_k - 1'b1};
                    n_k   = r_k - 1'b1;
                end
            end
            S_AWR: begin
                we = 1'b1; waddr = r_page; wdata = '{1'b0, 1'b1, r_want};
                n_ok = 1'b1;
                n_off = REGION_BITS'({r_page, {PAGE_BITS{1'b0}}});
                n_ord = r_want;
                n_st = S_OUT;
            end
            S_FRD: begin
                // Hold the read on the freed page.
                raddr = r_page;
                n_st  = S_FCHK;
            end
            S_FCHK: begin
                if (!rdata.alloc_h) begin
                    n_st = S_OUT;
                end else begin
                    we = 1'b1; waddr = r_page; wdata = '0;
                    n_k = rdata.order; n_ok = 1'b1;
                    raddr = r_page ^ PW'(({{(PW-1){1'b0}}, 1'b1}) << rdata.order);
                    n_st = (rdata.order >= ORD_W'(TOP)) ? S_FWR : S_BRD;
                end
            end
            S_BRD: begin
                // Hold the read on the buddy.
                raddr = buddy;
                n_st  = S_BCHK;
            end
            S_BCHK: begin
                if (rdata.free_h && rdata.order == r_k) begin
                    we = 1'b1; waddr = buddy; wdata = '0;
                    if (buddy < r_page) n_page = buddy;
                    n_k = r_k + 1'b1;
                    raddr = n_page ^ PW'(({{(PW-1){1'b0}}, 1'b1}) << n_k);
                    n_st = (n_k >= ORD_W'(TOP)) ? S_FWR : S_BRD;
                end else begin
                    n_st = S_FWR;
                end
            end
            S_FWR: begin
                we = 1'b1; waddr = r_page; wdata = '{1'b1, 1'b0, r_k};
                n_st = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_pg <= '0;
        end else begin
            r_st <= n_st; r_pg <= n_pg;
        end
        r_best <= n_best; r_bord <= n_bord; r_found <= n_found;
        r_want <= n_want; r_k <= n_k; r_page <= n_page;
        r_ok <= n_ok; r_off <= n_off; r_ord <= n_ord;
    end
endmodule
`default_nettype wire

### src/bba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_ok,
    input wire logic [19:0] o_result_offset,
    input wire logic [3:0]  o_result_order
);
    // Never take an item while a result is shown.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready with result pending");
    // Failed items carry zero payload.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_result_offset == '0 && o_result_order == '0))
        else $error("nonzero payload on failure");
    // Offset aligned to block order (in pages).
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> ((o_result_offset >> 12) & ((20'd1 << o_result_order) - 1)) == 0)
        else $error("misaligned block");
    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_offset)))
        else $error("result dropped");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_ok(o_ok), .o_result_offset(o_result_offset),
    .o_result_order(o_result_order)
);
`default_nettype wire

### test/buddy_block_allocator_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_check
// Watches both channels of the buddy allocator, keeps its own page map to
// work out each result, and compares every result item with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module buddy_block_allocator_check
    import bba_pkg::*;
#(
    parameter int PAGE_BITS   = 12,
    parameter int REGION_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_ready,
    input  logic                   i_cmd,
    input  logic [20:0]            i_request_bytes,
    input  logic [REGION_BITS-1:0] i_block_offset,
    input  logic                   i_out_valid,
    input  logic                   i_ready,
    input  logic                   i_ok,
    input  logic [REGION_BITS-1:0] i_result_offset,
    input  logic [ORD_W-1:0]       i_result_order,
    output int                     o_fail_count,
    output int                     o_pending
);
    localparam int TOP   = REGION_BITS - PAGE_BITS;
    localparam int PAGES = 1 << TOP;

    typedef struct packed {
        logic                   ok;
        logic [REGION_BITS-1:0] offset;
        logic [ORD_W-1:0]       order;
    } t_grant;

    t_entry page_map [PAGES];
    t_grant grant_q[$];
    int     fails;

    assign o_fail_count = fails;
    assign o_pending    = grant_q.size();

    function automatic int fit_order(logic [20:0] bytes);
        for (int k = 0; k <= TOP; k++)
            if ((64'd1 << (PAGE_BITS + k)) >= {43'd0, bytes}) return k;
        return -1;
    endfunction

    function automatic t_grant grant_block(logic [20:0] bytes);
        t_grant g;
        int want;
        g = '0;
        want = fit_order(bytes);
        if (want < 0) return g;
        for (int k = want; k <= TOP; k++) begin
            for (int p = 0; p < PAGES; p += (1 << k)) begin
                if (page_map[p].free_h && page_map[p].order == k) begin
                    page_map[p].free_h = 1'b0;
                    // split down, hand out the left half
                    for (int j = k - 1; j >= want; j--) begin
                        page_map[p + (1 << j)].free_h = 1'b1;
                        page_map[p + (1 << j)].order  = ORD_W'(j);
                    end
                    page_map[p].alloc_h = 1'b1;
                    page_map[p].order   = ORD_W'(want);
                    g.ok     = 1'b1;
                    g.offset = REGION_BITS'(p << PAGE_BITS);
                    g.order  = ORD_W'(want);
                    return g;
                end
            end
        end
        return g;
    endfunction

    function automatic t_grant release_block(logic [REGION_BITS-1:0] off);
        t_grant g;
        int pg, o, b;
        g = '0;
        if (off[PAGE_BITS-1:0] != 0) return g;
        pg = off >> PAGE_BITS;
        if (pg >= PAGES || !page_map[pg].alloc_h) return g;
        page_map[pg].alloc_h = 1'b0;
        o = page_map[pg].order;
        // merge with the buddy while it is a free block of the same order
        while (o < TOP) begin
            b = pg ^ (1 << o);
            if (!(page_map[b].free_h && page_map[b].order == o)) break;
            page_map[b].free_h = 1'b0;
            page_map[b].order  = '0;
            if (b < pg) begin
                page_map[pg].order = '0;
                pg = b;
            end
            o++;
        end
        page_map[pg].free_h = 1'b1;
        page_map[pg].order  = ORD_W'(o);
        g.ok = 1'b1;
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want_g;
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) page_map[p] = '0;
            page_map[0].free_h = 1'b1;
            page_map[0].order  = ORD_W'(TOP);
            grant_q.delete();
            fails = 0;
        end else begin
            if (i_valid && i_in_ready) begin
                if (i_cmd == CMD_ALLOC) grant_q.push_back(grant_block(i_request_bytes));
                else grant_q.push_back(release_block(i_block_offset));
            end
            if (i_out_valid && i_ready) begin
                if (grant_q.size() == 0) begin
                    $display("%t: unexpected result ok=%0d off=%h ord=%0d", $time,
                             i_ok, i_result_offset, i_result_order);
                    fails++;
                end else begin
                    want_g = grant_q.pop_front();
                    if (want_g.ok !== i_ok) begin
                        $display("%t: ok exp %0d got %0d", $time, want_g.ok, i_ok);
                        fails++;
                    end
                    if (want_g.offset !== i_result_offset) begin
                        $display("%t: offset exp %h got %h", $time, want_g.offset,
                                 i_result_offset);
                        fails++;
                    end
                    if (want_g.order !== i_result_order) begin
                        $display("%t: order exp %0d got %0d", $time, want_g.order,
                                 i_result_order);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

### test/buddy_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// Drives alloc and free items into the buddy allocator in bursts, stalls
// the result side on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module buddy_block_allocator_test;
    import bba_pkg::*;

    localparam int PAGE_BITS   = 12;
    localparam int REGION_BITS = 20;
    localparam int N_RANDOM    = 400;
    // a full scan can visit up to 256 block heads, plus long receiver stalls
    localparam int IDLE_LIMIT  = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [20:0]            req_bytes;
    logic [REGION_BITS-1:0] blk_off;
    logic                   out_valid;
    logic                   out_ready;
    logic                   res_ok;
    logic [REGION_BITS-1:0] res_off;
    logic [ORD_W-1:0]       res_ord;
    int                     fail_count;
    int                     pending;
    bit                     hold_off;

    // offsets handed out so far, so frees can hit live blocks
    logic [REGION_BITS-1:0] live_blocks[$];

    buddy_block_allocator #(.PAGE_BITS(PAGE_BITS), .REGION_BITS(REGION_BITS)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_cmd(cmd), .i_request_bytes(req_bytes), .i_block_offset(blk_off),
        .o_valid(out_valid), .i_ready(out_ready), .o_ok(res_ok),
        .o_result_offset(res_off), .o_result_order(res_ord)
    );

    buddy_block_allocator_check #(.PAGE_BITS(PAGE_BITS), .REGION_BITS(REGION_BITS)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_request_bytes(req_bytes), .i_block_offset(blk_off),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_ok(res_ok),
        .i_result_offset(res_off), .i_result_order(res_ord),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // Collect granted offsets: accepted ok results with a nonzero offset or order.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready && res_ok && res_off != 0)
            live_blocks.push_back(res_off);
        else if (rst_n && out_valid && out_ready && res_ok && res_ord != 0)
            live_blocks.push_back(res_off);
    end

    // Send one item: raise valid, hold the payload until accepted.
    task automatic send_item(logic c, logic [20:0] bytes, logic [REGION_BITS-1:0] off);
        in_valid  <= 1'b1;
        cmd       <= c;
        req_bytes <= bytes;
        blk_off   <= off;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random request size: mostly small blocks, sometimes huge or odd.
    function automatic logic [20:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 21'($urandom);
            1:       return 21'($urandom_range(0, 1 << 20));
            2, 3:    return 21'($urandom_range(0, 4096));
            default: return 21'($urandom_range(1, 65536));
        endcase
    endfunction

    // Random free target: usually a live block, otherwise noise.
    function automatic logic [REGION_BITS-1:0] pick_free();
        int idx;
        logic [REGION_BITS-1:0] off;
        if (live_blocks.size() != 0 && $urandom_range(0, 9) < 7) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[idx];
            live_blocks.delete(idx);
            return off;
        end
        if ($urandom_range(0, 1)) return REGION_BITS'($urandom);
        return {8'($urandom_range(0, 255)), 12'd0};
    endfunction

    // Receiver: stall on its own pattern, with one long hold-off.
    initial begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off) begin
                out_ready <= 1'b0;
                for (int i = 0; i < 3000; i++) @(posedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b0;
                default: out_ready <= 1'b1;
            endcase
            @(posedge clk);
        end
    end

    // Watchdog: count cycles with no accepted item on either channel.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int burst;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_ALLOC;
        req_bytes <= '0;
        blk_off   <= '0;
        hold_off  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, whole region, oversize, exhaustion, bad frees.
        send_item(CMD_ALLOC, 21'd0, '0);
        send_item(CMD_ALLOC, 21'd4097, '0);
        send_item(CMD_ALLOC, 21'd1048576, '0);
        send_item(CMD_ALLOC, 21'd1048577, '0);
        send_item(CMD_ALLOC, 21'h1FFFFF, '0);
        send_item(CMD_FREE, '0, 20'h00001);
        send_item(CMD_FREE, '0, 20'h05000);
        send_item(CMD_FREE, '0, 20'h00000);
        send_item(CMD_FREE, '0, 20'h00000);
        send_item(CMD_FREE, '0, 20'h02000);
        send_item(CMD_ALLOC, 21'd1048576, '0);
        send_item(CMD_ALLOC, 21'd1, '0);
        send_item(CMD_FREE, '0, 20'h00000);
        send_item(CMD_FREE, '0, 20'hFFFFF);
        send_item(CMD_ALLOC, 21'd524288, '0);
        send_item(CMD_ALLOC, 21'd4096, '0);
        send_item(CMD_FREE, '0, 20'h80000);
        send_item(CMD_FREE, '0, 20'h00000);
        drop_valid();

        // Fill the block while the receiver holds off.
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) send_item(CMD_ALLOC, 21'd8192, '0);
        drop_valid();

        // Random bursts with random gaps.
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) begin
                if ($urandom_range(0, 1))
                    send_item(CMD_ALLOC, pick_size(), REGION_BITS'($urandom));
                else
                    send_item(CMD_FREE, 21'($urandom), pick_free());
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        // Drain; the watchdog catches a hang.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### sim.f
src/bba_pkg.sv
src/bba_ram.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
test/buddy_block_allocator_check.sv
test/buddy_block_allocator_test.sv
